>>> hdl/gcdu_pkg.sv
// ============================================================================
// gcdu_pkg - Gregorian date unit shared definitions
// Field widths, request and compare codes, the date record and the calendar
// tables and helpers used by the step, info and top-level modules.
// ============================================================================
package gcdu_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int DELTA_W = 15;
    localparam int REQ_W   = 3;
    localparam int WDAY_W  = 3;
    localparam int MASK_W  = 7;
    localparam int DOY_W   = 9;
    localparam int CMP_W   = 2;

    // signed working width of a candidate year (current year plus any delta)
    localparam int CAND_W  = 17;
    // width of the weekday congruence sum before the mod-7 reduction
    localparam int WSUM_W  = 15;

    // floor(y / 100) = (y * 5243) >> 19, exact for every 14-bit year
    localparam int DIV100_MUL_W  = 13;
    localparam int DIV100_PROD_W = YEAR_W + DIV100_MUL_W;
    localparam int DIV100_SHIFT  = 19;
    localparam int Q100_W        = DIV100_PROD_W - DIV100_SHIFT;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = DIV100_MUL_W'(5243);

    // floor(s / 7) approximated by (s * 9362) >> 16, low by at most one
    localparam int MOD7_MUL_W  = 14;
    localparam int MOD7_PROD_W = WSUM_W + MOD7_MUL_W;
    localparam int MOD7_SHIFT  = 16;
    localparam int Q7_W        = MOD7_PROD_W - MOD7_SHIFT;
    localparam logic [MOD7_MUL_W-1:0] MOD7_MUL = MOD7_MUL_W'(9362);
    localparam logic [WDAY_W-1:0] DAYS_PER_WEEK = WDAY_W'(7);

    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    localparam logic [DAY_W-1:0] FEB_DAYS      = DAY_W'(28);
    localparam logic [DAY_W-1:0] FEB_LEAP_DAY  = DAY_W'(29);
    localparam logic [DAY_W-1:0] LONG_MONTH    = DAY_W'(31);

    localparam logic [YEAR_W-1:0] YEAR_MIN = YEAR_W'(1);
    localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);

    localparam logic [DAY_W-1:0]   RESET_DAY   = DAY_W'(1);
    localparam logic [MONTH_W-1:0] RESET_MONTH = MONTH_W'(1);
    localparam logic [YEAR_W-1:0]  RESET_YEAR  = YEAR_W'(2000);
    localparam logic [MASK_W-1:0]  RESET_WEEKEND_MASK = MASK_W'(96);

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD       = 3'd0,
        REQ_NEXT_DAY   = 3'd1,
        REQ_PREV_DAY   = 3'd2,
        REQ_NEXT_MONTH = 3'd3,
        REQ_PREV_MONTH = 3'd4,
        REQ_ADD_YEARS  = 3'd5
    } req_t;

    typedef enum logic [CMP_W-1:0] {
        CMP_BEFORE = 2'd0,
        CMP_EQUAL  = 2'd1,
        CMP_AFTER  = 2'd2
    } cmp_t;

    // year on top so that the packed value orders chronologically
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef struct packed {
        date_t date;
        logic  leap;
        logic  err;
    } step_t;

    function automatic logic is_leap_year(input logic [YEAR_W-1:0] y);
        logic [DIV100_PROD_W-1:0] prod;
        logic [Q100_W-1:0]        q;
        logic [YEAR_W-1:0]        back;
        prod = DIV100_PROD_W'(y) * DIV100_PROD_W'(DIV100_MUL);
        q    = prod[DIV100_PROD_W-1:DIV100_SHIFT];
        back = YEAR_W'(q) * YEAR_W'(100);
        // century years are leap only when the century count is a multiple of 4
        return (y[1:0] == 2'b00) && ((y != back) || (q[1:0] == 2'b00));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        if (m == MONTH_FEB)
            len = FEB_DAYS + DAY_W'(leap);
        else if (m inside {4'd4, 4'd6, 4'd9, 4'd11})
            len = DAY_W'(30);
        else
            len = LONG_MONTH;
        return len;
    endfunction

    // days in the year before the first of month m (non-leap)
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] d;
        case (m)
            4'd2:    d = DOY_W'(31);
            4'd3:    d = DOY_W'(59);
            4'd4:    d = DOY_W'(90);
            4'd5:    d = DOY_W'(120);
            4'd6:    d = DOY_W'(151);
            4'd7:    d = DOY_W'(181);
            4'd8:    d = DOY_W'(212);
            4'd9:    d = DOY_W'(243);
            4'd10:   d = DOY_W'(273);
            4'd11:   d = DOY_W'(304);
            4'd12:   d = DOY_W'(334);
            default: d = DOY_W'(0);
        endcase
        return d;
    endfunction

    // floor(31 * mm / 12) with mm counted from March (Jan and Feb close the year)
    function automatic logic [DAY_W-1:0] wday_month_term(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] t;
        case (m)
            4'd1:    t = DAY_W'(28);
            4'd2:    t = DAY_W'(31);
            4'd3:    t = DAY_W'(2);
            4'd4:    t = DAY_W'(5);
            4'd5:    t = DAY_W'(7);
            4'd6:    t = DAY_W'(10);
            4'd7:    t = DAY_W'(12);
            4'd8:    t = DAY_W'(15);
            4'd9:    t = DAY_W'(18);
            4'd10:   t = DAY_W'(20);
            4'd11:   t = DAY_W'(23);
            4'd12:   t = DAY_W'(25);
            default: t = DAY_W'(0);
        endcase
        return t;
    endfunction

endpackage

>>> hdl/gregorian_calendar_date_unit.sv
// ============================================================================
// gregorian_calendar_date_unit - Gregorian date register with step requests
// Holds one date and serves load, day, month and year steps, reporting the
// new date and its derived calendar facts for every request.
// ============================================================================
// The unit takes one request beat per clock while the result side keeps up
// and returns one result beat per request, in order. A result reaches the
// master side through the input register, then the registers after the date
// step, the derived facts and the weekday reduction; throughput is one beat
// per cycle when no stage is stalled, set by the date step, which reads and
// rewrites the stored date as the beat leaves the input register, so that each
// request sees the date left by the one before it. Every stage holds its beat
// until the next one is free, so a stalled result does not stop request beats
// from entering while empty stages remain. A rejected load or a step whose
// year leaves 1..9999 returns the unchanged date with error set. Request codes
// 6 and 7 leave the date alone and report it. compare_result weighs the date
// after the step against the request's day, month and year as raw numbers.
// weekend_mask (Sunday in bit 0) is written through cfg_wr_en/cfg_wr_data and
// must only change while no beat is in flight. After reset the date is
// 1 January 2000 and the mask marks Friday and Saturday.
// ============================================================================
module gregorian_calendar_date_unit
    import gcdu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_wr_en,
    input  logic [MASK_W-1:0] cfg_wr_data,     // weekend_mask

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [39:0]       s_axis_tdata,    // in_day[4:0], in_month[8:5],
                                               // in_year[22:9], year_delta[37:23]
    input  logic [REQ_W-1:0]  s_axis_tuser,    // req_type[2:0]

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata     // out_day[4:0], out_month[8:5],
                                               // out_year[22:9], weekday[25:23],
                                               // is_weekend[26], is_leap[27],
                                               // is_month_end[28],
                                               // month_length[33:29],
                                               // day_of_year[42:34],
                                               // compare_result[44:43], error[45]
);

    // ---------------------------------------------------------------- config
    logic [MASK_W-1:0] weekend_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            weekend_mask_reg <= RESET_WEEKEND_MASK;
        else if (cfg_wr_en)
            weekend_mask_reg <= cfg_wr_data;
    end

    // ------------------------------------------------------------- flow ctrl
    logic s0_valid_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_free, s2_free, s1_free, s0_free;
    logic s2_move, s1_move, s0_move;
    logic in_fire;

    // a stage is free when empty or when its beat moves on this edge
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s2_move  = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || s2_move;
    assign s1_move  = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_move;
    assign s0_move  = s0_valid_reg && s1_free;
    assign s0_free  = !s0_valid_reg || s0_move;

    assign s_axis_tready = s0_free;
    assign in_fire       = s_axis_tvalid && s0_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_free)
                s0_valid_reg <= s_axis_tvalid;
            if (s1_free)
                s1_valid_reg <= s0_valid_reg;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (out_free)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // ------------------------------------------------------- input register
    logic [REQ_W-1:0]          s0_req_reg;
    date_t                     s0_date_reg;
    logic signed [DELTA_W-1:0] s0_delta_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s0_req_reg        <= s_axis_tuser;
            s0_date_reg.day   <= s_axis_tdata[4:0];
            s0_date_reg.month <= s_axis_tdata[8:5];
            s0_date_reg.year  <= s_axis_tdata[22:9];
            s0_delta_reg      <= signed'(s_axis_tdata[37:23]);
        end
    end

    // ------------------------------------------------------ date step/state
    date_t cur_date_reg;
    logic  cur_leap_reg;
    step_t step;

    gcdu_step u_step (
        .req        (s0_req_reg),
        .in_date    (s0_date_reg),
        .year_delta (s0_delta_reg),
        .cur_date   (cur_date_reg),
        .cur_leap   (cur_leap_reg),
        .result     (step)
    );

    // the stored date advances as each request leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_date_reg.day   <= RESET_DAY;
            cur_date_reg.month <= RESET_MONTH;
            cur_date_reg.year  <= RESET_YEAR;
            cur_leap_reg       <= is_leap_year(RESET_YEAR);
        end
        else if (s0_move)
        begin
            cur_date_reg <= step.date;
            cur_leap_reg <= step.leap;
        end
    end

    date_t s1_date_reg;
    date_t s1_in_reg;
    logic  s1_leap_reg;
    logic  s1_err_reg;

    always_ff @(posedge clk)
    begin
        if (s0_move)
        begin
            s1_date_reg <= step.date;
            s1_leap_reg <= step.leap;
            s1_err_reg  <= step.err;
            s1_in_reg   <= s0_date_reg;
        end
    end

    // --------------------------------------------------------- derived facts
    logic [DAY_W-1:0]  info_len;
    logic [DOY_W-1:0]  info_doy;
    cmp_t              info_cmp;
    logic [WSUM_W-1:0] info_sum;

    gcdu_info u_info (
        .date           (s1_date_reg),
        .leap           (s1_leap_reg),
        .in_date        (s1_in_reg),
        .month_length   (info_len),
        .day_of_year    (info_doy),
        .compare_result (info_cmp),
        .wday_sum       (info_sum)
    );

    date_t             s2_date_reg;
    logic              s2_leap_reg;
    logic              s2_err_reg;
    logic [DAY_W-1:0]  s2_len_reg;
    logic [DOY_W-1:0]  s2_doy_reg;
    cmp_t              s2_cmp_reg;
    logic [WSUM_W-1:0] s2_sum_reg;

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_date_reg <= s1_date_reg;
            s2_leap_reg <= s1_leap_reg;
            s2_err_reg  <= s1_err_reg;
            s2_len_reg  <= info_len;
            s2_doy_reg  <= info_doy;
            s2_cmp_reg  <= info_cmp;
            s2_sum_reg  <= info_sum;
        end
    end

    // ------------------------------------------------ weekday, result pack
    logic [MOD7_PROD_W-1:0] mod_prod;
    logic [Q7_W-1:0]        q7;
    logic [WSUM_W-1:0]      q7_times7;
    logic [WSUM_W-1:0]      rem_wide;
    logic [3:0]             rem;
    logic [WDAY_W-1:0]      wday;
    logic [47:0]            out_data_next;
    logic [47:0]            out_data_reg;

    // reciprocal quotient is low by at most one, so the remainder is below 14
    assign mod_prod  = MOD7_PROD_W'(s2_sum_reg) * MOD7_PROD_W'(MOD7_MUL);
    assign q7        = mod_prod[MOD7_PROD_W-1:MOD7_SHIFT];
    assign q7_times7 = WSUM_W'({q7, 3'b000}) - WSUM_W'(q7);
    assign rem_wide  = s2_sum_reg - q7_times7;
    assign rem       = rem_wide[3:0];
    assign wday      = (rem >= 4'(DAYS_PER_WEEK)) ? WDAY_W'(rem - 4'(DAYS_PER_WEEK))
                                                  : WDAY_W'(rem);

    assign out_data_next = {
        2'b00,
        s2_err_reg,
        s2_cmp_reg,
        s2_doy_reg,
        s2_len_reg,
        (s2_date_reg.day == s2_len_reg),
        s2_leap_reg,
        weekend_mask_reg[wday],
        wday,
        s2_date_reg.year,
        s2_date_reg.month,
        s2_date_reg.day
    };

    always_ff @(posedge clk)
    begin
        if (s2_move)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ------------------------------------------------------------ assertions
`ifndef ASSERT_OFF
    // the stored date is always a real calendar date
    a_date_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_date_reg.month >= MONTH_JAN) && (cur_date_reg.month <= MONTH_DEC) &&
        (cur_date_reg.day != '0) &&
        (cur_date_reg.day <= month_len(cur_date_reg.month, cur_leap_reg)) &&
        (cur_date_reg.year >= YEAR_MIN) && (cur_date_reg.year <= YEAR_MAX))
        else $error("stored date is not a valid date");

    // the tracked leap flag follows the stored year
    a_leap_track: assert property (@(posedge clk) disable iff (!rst_n)
        cur_leap_reg == is_leap_year(cur_date_reg.year))
        else $error("stored leap flag disagrees with stored year");

    // a failing request leaves the stored date untouched
    a_err_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s0_move && step.err) |=> $stable(cur_date_reg) && $stable(cur_leap_reg))
        else $error("error step changed the stored date");

    // result beat carries a reduced weekday and a day inside its month
    a_out_sane: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[25:23] < DAYS_PER_WEEK) &&
                          (m_axis_tdata[4:0] <= m_axis_tdata[33:29]))
        else $error("result beat has out-of-range weekday or day");
`endif

endmodule

>>> hdl/gcdu_step.sv
// ============================================================================
// gcdu_step - date step logic
// Next stored date, leap flag and error for one request against the current
// date. Purely combinational; the caller registers the result.
// ============================================================================
module gcdu_step
    import gcdu_pkg::*;
(
    input  logic [REQ_W-1:0]          req,
    input  date_t                     in_date,
    input  logic signed [DELTA_W-1:0] year_delta,
    input  date_t                     cur_date,
    input  logic                      cur_leap,
    output step_t                     result
);

    logic signed [CAND_W-1:0] year_off;
    logic signed [CAND_W-1:0] cand;
    logic                     cand_ok;
    logic                     cand_leap;
    logic [YEAR_W-1:0]        cand_year;
    logic [DAY_W-1:0]         cur_len;
    logic [DAY_W-1:0]         in_len;
    logic [DAY_W-1:0]         prev_len;
    logic [DAY_W-1:0]         tgt_len;
    logic [MONTH_W-1:0]       prev_month;
    logic [MONTH_W-1:0]       tgt_month;
    logic                     month_wrap;
    logic                     year_chg;
    logic                     bad;
    date_t                    nd;
    logic                     nleap;

    // one candidate year per request; the step decides whether it is taken
    always_comb
    begin
        case (req)
            REQ_ADD_YEARS:                  year_off = CAND_W'(year_delta);
            REQ_NEXT_DAY, REQ_NEXT_MONTH:   year_off = CAND_W'(1);
            REQ_PREV_DAY, REQ_PREV_MONTH:   year_off = -CAND_W'(1);
            default:                        year_off = '0;
        endcase
    end

    assign cand = (req == REQ_LOAD) ? signed'(CAND_W'(in_date.year))
                                    : signed'(CAND_W'(cur_date.year)) + year_off;
    assign cand_ok   = (cand >= signed'(CAND_W'(YEAR_MIN))) &&
                       (cand <= signed'(CAND_W'(YEAR_MAX)));
    assign cand_year = cand[YEAR_W-1:0];
    assign cand_leap = is_leap_year(cand_year);

    assign cur_len    = month_len(cur_date.month, cur_leap);
    assign in_len     = month_len(in_date.month, cand_leap);
    assign prev_month = cur_date.month - MONTH_W'(1);
    assign prev_len   = month_len(prev_month, cur_leap);

    // month steps: a wrap lands on January or December, both 31 days long
    always_comb
    begin
        if (req == REQ_NEXT_MONTH)
        begin
            month_wrap = (cur_date.month == MONTH_DEC);
            tgt_month  = month_wrap ? MONTH_JAN : cur_date.month + MONTH_W'(1);
        end
        else
        begin
            month_wrap = (cur_date.month == MONTH_JAN);
            tgt_month  = month_wrap ? MONTH_DEC : prev_month;
        end
    end
    assign tgt_len = month_len(tgt_month, cur_leap);

    always_comb
    begin
        nd       = cur_date;
        nleap    = cur_leap;
        year_chg = 1'b0;
        bad      = 1'b0;
        case (req)
            REQ_LOAD:
            begin
                if ((in_date.month >= MONTH_JAN) && (in_date.month <= MONTH_DEC) &&
                    cand_ok && (in_date.day != '0) && (in_date.day <= in_len))
                begin
                    nd.day   = in_date.day;
                    nd.month = in_date.month;
                    year_chg = 1'b1;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            REQ_NEXT_DAY:
            begin
                if (cur_date.day == cur_len)
                begin
                    nd.day = DAY_W'(1);
                    if (cur_date.month == MONTH_DEC)
                    begin
                        nd.month = MONTH_JAN;
                        year_chg = 1'b1;
                    end
                    else
                    begin
                        nd.month = cur_date.month + MONTH_W'(1);
                    end
                end
                else
                begin
                    nd.day = cur_date.day + DAY_W'(1);
                end
            end
            REQ_PREV_DAY:
            begin
                if (cur_date.day == DAY_W'(1))
                begin
                    if (cur_date.month == MONTH_JAN)
                    begin
                        nd.month = MONTH_DEC;
                        nd.day   = LONG_MONTH;
                        year_chg = 1'b1;
                    end
                    else
                    begin
                        nd.month = prev_month;
                        nd.day   = prev_len;
                    end
                end
                else
                begin
                    nd.day = cur_date.day - DAY_W'(1);
                end
            end
            REQ_NEXT_MONTH, REQ_PREV_MONTH:
            begin
                nd.month = tgt_month;
                nd.day   = (cur_date.day > tgt_len) ? tgt_len : cur_date.day;
                year_chg = month_wrap;
            end
            REQ_ADD_YEARS:
            begin
                year_chg = 1'b1;
                // Feb 29 falls back to the 28th in a common year
                if ((cur_date.month == MONTH_FEB) && (cur_date.day == FEB_LEAP_DAY) &&
                    !cand_leap)
                    nd.day = FEB_DAYS;
            end
            default:
            begin
            end
        endcase

        if (year_chg)
        begin
            nd.year = cand_year;
            nleap   = cand_leap;
            if (!cand_ok)
                bad = 1'b1;
        end

        // any error keeps the stored date as it was
        if (bad)
        begin
            nd    = cur_date;
            nleap = cur_leap;
        end
    end

    assign result.date = nd;
    assign result.leap = nleap;
    assign result.err  = bad;

endmodule

>>> hdl/gcdu_info.sv
// ============================================================================
// gcdu_info - derived date facts
// Month length, day of year, comparison with the request's date and the
// weekday congruence sum (reduced mod 7 one stage later).
// ============================================================================
module gcdu_info
    import gcdu_pkg::*;
(
    input  date_t              date,
    input  logic               leap,
    input  date_t              in_date,
    output logic [DAY_W-1:0]   month_length,
    output logic [DOY_W-1:0]   day_of_year,
    output cmp_t               compare_result,
    output logic [WSUM_W-1:0]  wday_sum
);

    logic                       early;
    logic [YEAR_W-1:0]          yy;
    logic [DIV100_PROD_W-1:0]   prod;
    logic [Q100_W-1:0]          q100;
    logic [Q100_W-1:0]          q400;

    assign month_length = month_len(date.month, leap);

    assign day_of_year = days_before(date.month) + DOY_W'(date.day) +
                         DOY_W'((date.month > MONTH_FEB) && leap);

    always_comb
    begin
        if (date == in_date)
            compare_result = CMP_EQUAL;
        else if (date < in_date)
            compare_result = CMP_BEFORE;
        else
            compare_result = CMP_AFTER;
    end

    // January and February count as months of the previous year
    assign early = (date.month <= MONTH_FEB);
    assign yy    = date.year - YEAR_W'(early);
    assign prod  = DIV100_PROD_W'(yy) * DIV100_PROD_W'(DIV100_MUL);
    assign q100  = prod[DIV100_PROD_W-1:DIV100_SHIFT];
    assign q400  = q100 >> 2;

    assign wday_sum = WSUM_W'(date.day) + WSUM_W'(yy) + WSUM_W'(yy >> 2) +
                      WSUM_W'(q400) + WSUM_W'(wday_month_term(date.month)) -
                      WSUM_W'(q100);

endmodule

>>> bench/gregorian_calendar_date_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// gregorian_calendar_date_unit_tb - self-checking bench for the date unit
// Feeds request beats from a queue, predicts every result beat with an
// independent calendar model and checks the master stream field by field.
// Covers loads, day/month/year steps, range errors and weekend mask changes,
// with random bursts on the request side and random stalls on the result side.
// ============================================================================
module gregorian_calendar_date_unit_tb;
    import gcdu_pkg::*;

    // request codes the unit treats as no-ops
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_SETTLE = 8;     // quiet cycles before a mask write or drain
    localparam int TAIL_CYCLES  = 12;    // pipeline is four deep
    localparam int HOLD_AT_A    = 1200;
    localparam int HOLD_AT_B    = 4000;
    localparam int HOLD_CYCLES  = 250;

    typedef enum logic [1:0] {
        OP_BEAT,
        OP_CFG_WRITE,
        OP_DRAIN
    } op_kind_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_TOGGLE
    } sink_mode_t;

    typedef struct packed {
        logic [REQ_W-1:0]   code;
        logic [DELTA_W-1:0] delta;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_req_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [MASK_W-1:0] mask;
        date_req_t         req;
    } pending_op_t;

    // same layout as m_axis_tdata, LSB field last
    typedef struct packed {
        logic [1:0]         spare;
        logic               error;
        logic [CMP_W-1:0]   cmp;
        logic [DOY_W-1:0]   doy;
        logic [DAY_W-1:0]   mlen;
        logic               month_end;
        logic               leap;
        logic               weekend;
        logic [WDAY_W-1:0]  wday;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [MASK_W-1:0] cfg_wr_data = RESET_WEEKEND_MASK;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [39:0]       s_axis_tdata = '0;   // in_day[4:0], in_month[8:5],
                                            // in_year[22:9], year_delta[37:23]
    logic [REQ_W-1:0]  s_axis_tuser = '0;   // req_type[2:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [47:0]       m_axis_tdata;        // out_day[4:0], out_month[8:5],
                                            // out_year[22:9], weekday[25:23],
                                            // is_weekend[26], is_leap[27],
                                            // is_month_end[28],
                                            // month_length[33:29],
                                            // day_of_year[42:34],
                                            // compare_result[44:43], error[45]

    gregorian_calendar_date_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Calendar predictor: shadow date and weekend mask, advanced once per
    // accepted request beat.
    // ------------------------------------------------------------------------
    int                cal_day      = int'(RESET_DAY);
    int                cal_month    = int'(RESET_MONTH);
    int                cal_year     = int'(RESET_YEAR);
    logic [MASK_W-1:0] weekend_bits = RESET_WEEKEND_MASK;

    pending_op_t  pending_ops[$];
    date_result_t date_results[$];
    date_req_t    offered_req;
    int           fail_count = 0;

    function automatic logic leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_days(input int m, input int y);
        case (m)
            2:             return leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // congruence with March as month 1 of the shifted year
    function automatic int weekday_from(input int d, input int m, input int y);
        int a;
        int yy;
        int mm;
        a  = (14 - m) / 12;
        yy = y - a;
        mm = m + 12 * a - 2;
        return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
    endfunction

    function automatic int ordinal_day(input int d, input int m, input int y);
        int total;
        total = d;
        for (int k = 1; k < m; k++)
            total += month_days(k, y);
        return total;
    endfunction

    function automatic date_result_t advance_calendar(input date_req_t r);
        int           nd;
        int           nm;
        int           ny;
        int           wd;
        int           len;
        logic         fault;
        date_result_t res;
        nd    = cal_day;
        nm    = cal_month;
        ny    = cal_year;
        fault = 1'b0;
        case (r.code)
            REQ_LOAD:
                if (r.month >= 1 && r.month <= 12 && r.year >= 1 && r.year <= 9999 &&
                    r.day >= 1 && r.day <= month_days(int'(r.month), int'(r.year)))
                begin
                    nd = int'(r.day);
                    nm = int'(r.month);
                    ny = int'(r.year);
                end
                else
                    fault = 1'b1;
            REQ_NEXT_DAY:
                if (nd == month_days(nm, ny))
                begin
                    nd = 1;
                    if (nm == 12)
                    begin
                        nm = 1;
                        ny++;
                    end
                    else
                        nm++;
                end
                else
                    nd++;
            REQ_PREV_DAY:
                if (nd == 1)
                begin
                    if (nm == 1)
                    begin
                        nm = 12;
                        nd = 31;
                        ny--;
                    end
                    else
                    begin
                        nm--;
                        nd = month_days(nm, ny);
                    end
                end
                else
                    nd--;
            REQ_NEXT_MONTH, REQ_PREV_MONTH:
            begin
                if (r.code == REQ_NEXT_MONTH)
                begin
                    if (nm == 12)
                    begin
                        nm = 1;
                        ny++;
                    end
                    else
                        nm++;
                end
                else if (nm == 1)
                begin
                    nm = 12;
                    ny--;
                end
                else
                    nm--;
                if (ny >= 1 && ny <= 9999 && nd > month_days(nm, ny))
                    nd = month_days(nm, ny);
            end
            REQ_ADD_YEARS:
            begin
                ny = ny + int'($signed(r.delta));
                // leap day lands on the 28th in a common year
                if (ny >= 1 && ny <= 9999 && nm == 2 && nd == 29 && !leap_year(ny))
                    nd = 28;
            end
            default:
                ;
        endcase

        // out-of-range year: keep the old date, flag it
        if (ny < 1 || ny > 9999)
        begin
            fault = 1'b1;
            nd    = cal_day;
            nm    = cal_month;
            ny    = cal_year;
        end
        cal_day   = nd;
        cal_month = nm;
        cal_year  = ny;

        len = month_days(nm, ny);
        wd  = weekday_from(nd, nm, ny);
        res           = '0;
        res.day       = DAY_W'(nd);
        res.month     = MONTH_W'(nm);
        res.year      = YEAR_W'(ny);
        res.wday      = WDAY_W'(wd);
        res.weekend   = weekend_bits[wd];
        res.leap      = leap_year(ny);
        res.month_end = (nd == len);
        res.mlen      = DAY_W'(len);
        res.doy       = DOY_W'(ordinal_day(nd, nm, ny));
        res.error     = fault;
        // raw comparison against the request fields, valid date or not
        if (ny != r.year)
            res.cmp = (ny < r.year) ? CMP_BEFORE : CMP_AFTER;
        else if (nm != r.month)
            res.cmp = (nm < r.month) ? CMP_BEFORE : CMP_AFTER;
        else if (nd != r.day)
            res.cmp = (nd < r.day) ? CMP_BEFORE : CMP_AFTER;
        else
            res.cmp = CMP_EQUAL;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. Offers beats from pending_ops in bursts with random gaps.
    // A mask write or a drain marker waits until every result is back and the bus
    // has stayed quiet per DRAIN_SETTLE. Every output gets at most one NBA per edge.
    // ------------------------------------------------------------------------
    int burst_left;
    int gap_left;
    int quiet_cycles;

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        pending_op_t head;
        logic        offer;
        logic        wr_cfg;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            cfg_wr_en     <= 1'b0;
            cfg_wr_data   <= RESET_WEEKEND_MASK;
            burst_left    = 1;
            gap_left      = 0;
            quiet_cycles  = 0;
        end
        else
        begin
            offer  = s_axis_tvalid;
            wr_cfg = 1'b0;
            if (s_axis_tvalid && s_axis_tready)
            begin
                date_results.push_back(advance_calendar(offered_req));
                offer = 1'b0;
            end

            if (date_results.size() == 0 && !s_axis_tvalid)
                quiet_cycles++;
            else
                quiet_cycles = 0;

            if (!offer && pending_ops.size() != 0)
            begin
                head = pending_ops[0];
                case (head.kind)
                    OP_BEAT:
                        if (gap_left != 0)
                            gap_left--;
                        else
                        begin
                            void'(pending_ops.pop_front());
                            offer        = 1'b1;
                            offered_req  = head.req;
                            s_axis_tdata <= {2'b00, head.req.delta, head.req.year,
                                             head.req.month, head.req.day};
                            s_axis_tuser <= head.req.code;
                            burst_left--;
                            if (burst_left == 0)
                            begin
                                // a third of the bursts run back to back
                                burst_left = $urandom_range(1, 30);
                                gap_left   = ($urandom_range(0, 2) == 0) ?
                                             0 : $urandom_range(1, 8);
                            end
                        end
                    default:
                        if (quiet_cycles >= DRAIN_SETTLE)
                        begin
                            void'(pending_ops.pop_front());
                            quiet_cycles = 0;
                            if (head.kind == OP_CFG_WRITE)
                            begin
                                wr_cfg       = 1'b1;
                                cfg_wr_data  <= head.mask;
                                weekend_bits = head.mask;
                            end
                        end
                endcase
            end
            s_axis_tvalid <= offer;
            cfg_wr_en     <= wr_cfg;
        end
    end

    // ------------------------------------------------------------------------
    // Result sink. Switches between stall patterns; twice it holds off for a
    // long stretch so the pipeline fills and backs up into the request side.
    // ------------------------------------------------------------------------
    int         sink_cycles;
    int         hold_left;
    int         mode_left;
    sink_mode_t sink_mode;

    always @(posedge clk or negedge rst_n)
    begin : result_sink
        logic rdy;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_cycles   = 0;
            hold_left     = 0;
            mode_left     = 0;
            sink_mode     = SINK_OPEN;
        end
        else
        begin
            sink_cycles++;
            if (sink_cycles == HOLD_AT_A || sink_cycles == HOLD_AT_B)
                hold_left = HOLD_CYCLES;
            if (mode_left == 0)
            begin
                sink_mode = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 150);
            end
            else
                mode_left--;
            case (sink_mode)
                SINK_OPEN:   rdy = 1'b1;
                SINK_COIN:   rdy = ($urandom_range(0, 1) == 1);
                SINK_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                default:     rdy = !m_axis_tready;
            endcase
            if (hold_left != 0)
            begin
                rdy = 1'b0;
                hold_left--;
            end
            m_axis_tready <= rdy;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each accepted result beat against the oldest prediction.
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_checker
        date_result_t got;
        date_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (date_results.size() == 0)
            begin
                $display("%0t: result beat with nothing pending, expected none, actual %h",
                         $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = date_results.pop_front();
                compare_field("out_day",        int'(want.day),       int'(got.day));
                compare_field("out_month",      int'(want.month),     int'(got.month));
                compare_field("out_year",       int'(want.year),      int'(got.year));
                compare_field("weekday",        int'(want.wday),      int'(got.wday));
                compare_field("is_weekend",     int'(want.weekend),   int'(got.weekend));
                compare_field("is_leap",        int'(want.leap),      int'(got.leap));
                compare_field("is_month_end",   int'(want.month_end), int'(got.month_end));
                compare_field("month_length",   int'(want.mlen),      int'(got.mlen));
                compare_field("day_of_year",    int'(want.doy),       int'(got.doy));
                compare_field("compare_result", int'(want.cmp),       int'(got.cmp));
                compare_field("error",          int'(want.error),     int'(got.error));
            end
        end
    end

    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic push_beat(input logic [REQ_W-1:0] code, input int d, input int m,
                             input int y, input int dlt);
        pending_op_t op;
        op           = '0;
        op.kind      = OP_BEAT;
        op.req.code  = code;
        op.req.day   = DAY_W'(d);
        op.req.month = MONTH_W'(m);
        op.req.year  = YEAR_W'(y);
        op.req.delta = DELTA_W'(dlt);
        pending_ops.push_back(op);
    endtask

    task automatic push_marker(input op_kind_t kind, input logic [MASK_W-1:0] mask);
        pending_op_t op;
        op      = '0;
        op.kind = kind;
        op.mask = mask;
        pending_ops.push_back(op);
    endtask

    function automatic int full_delta();
        return int'($urandom_range(0, 19998)) - 9999;
    endfunction

    // valid date biased toward range ends, century years and month edges
    task automatic pick_date(output int d, output int m, output int y);
        int roll;
        int len;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            y = $urandom_range(1, 3);
        else if (roll < 20)
            y = $urandom_range(9997, 9999);
        else if (roll < 40)
            y = $urandom_range(1, 99) * 100;
        else
            y = $urandom_range(1, 9999);
        m   = $urandom_range(1, 12);
        len = month_days(m, y);
        roll = $urandom_range(0, 99);
        if (roll < 40)
            d = len - $urandom_range(0, 2);
        else if (roll < 60)
            d = $urandom_range(1, 2);
        else
            d = $urandom_range(1, len);
    endtask

    // Mostly a valid load followed by a run of steps; the rest is raw noise.
    task automatic add_random_beats(input int count);
        int               made;
        int               d;
        int               m;
        int               y;
        int               cy;
        int               roll;
        int               dlt;
        logic [REQ_W-1:0] code;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                push_beat(REQ_W'($urandom_range(0, 7)), $urandom_range(0, 31),
                          $urandom_range(0, 15), $urandom_range(0, 9999), full_delta());
                made++;
            end
            else
            begin
                pick_date(d, m, y);
                push_beat(REQ_LOAD, d, m, y, full_delta());
                made++;
                repeat ($urandom_range(1, 16))
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 35)
                        code = REQ_NEXT_DAY;
                    else if (roll < 60)
                        code = REQ_PREV_DAY;
                    else if (roll < 72)
                        code = REQ_NEXT_MONTH;
                    else if (roll < 84)
                        code = REQ_PREV_MONTH;
                    else if (roll < 96)
                        code = REQ_ADD_YEARS;
                    else
                        code = $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
                    dlt = ($urandom_range(0, 3) == 0) ? full_delta()
                                                      : int'($urandom_range(0, 10)) - 5;
                    // compare date near the loaded year so month/day decide often
                    if ($urandom_range(0, 1))
                        cy = y + int'($urandom_range(0, 2)) - 1;
                    else
                        cy = $urandom_range(0, 9999);
                    if (cy > 9999)
                        cy = 9999;
                    push_beat(code, $urandom_range(0, 31), $urandom_range(0, 15), cy, dlt);
                    made++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // directed part, reset weekend mask
        push_beat(REQ_SPARE_LO,   1,  1, 2000,     0);   // reset date, equal compare
        push_beat(REQ_LOAD,      31, 12, 9999,  9999);   // latest date
        push_beat(REQ_NEXT_DAY,  31, 12, 9999,     0);   // past year 9999
        push_beat(REQ_NEXT_MONTH, 1,  1, 9999,     0);
        push_beat(REQ_ADD_YEARS,  1,  1, 9999,     1);
        push_beat(REQ_LOAD,       1,  1,    1, -9999);   // earliest date
        push_beat(REQ_PREV_DAY,   1,  1,    1,     0);   // before year 1
        push_beat(REQ_PREV_MONTH, 1,  1,    1,     0);
        push_beat(REQ_ADD_YEARS,  1,  1,    1,  9998);   // to 9999
        push_beat(REQ_ADD_YEARS,  1,  1,    1, -9999);   // below year 1
        push_beat(REQ_LOAD,      29,  2, 2024,     0);
        push_beat(REQ_ADD_YEARS, 29,  2, 2024,     1);   // leap day clamps to 28th
        push_beat(REQ_LOAD,      31,  1, 2000,     0);
        push_beat(REQ_NEXT_MONTH, 0,  0,    0,     0);   // clamp to leap February
        push_beat(REQ_NEXT_MONTH, 0,  0,    0,     0);
        push_beat(REQ_PREV_MONTH, 0,  0,    0,     0);
        push_beat(REQ_LOAD,       1,  3, 1900,     0);
        push_beat(REQ_PREV_DAY,   1,  3, 1900,     0);   // century year, not leap
        push_beat(REQ_NEXT_DAY,   1,  3, 1900,     0);
        push_beat(REQ_LOAD,      29,  2, 1900,     0);   // invalid leap day
        push_beat(REQ_LOAD,       0, 15,    0,     0);   // invalid in every field
        push_beat(REQ_LOAD,      31,  4, 2023,     0);   // day past month end
        push_beat(REQ_LOAD,      31, 13, 9999,     0);   // month 13
        push_beat(REQ_SPARE_HI,  31, 15, 9999,    -1);

        // random phases, each under its own weekend mask
        push_marker(OP_CFG_WRITE, 7'h00);
        add_random_beats(390);
        push_marker(OP_CFG_WRITE, 7'h7F);
        add_random_beats(390);
        push_marker(OP_CFG_WRITE, MASK_W'($urandom_range(0, 127)));
        add_random_beats(200);
        push_marker(OP_DRAIN, '0);                       // sender waits for all results
        add_random_beats(190);
        push_marker(OP_CFG_WRITE, 7'h41);
        add_random_beats(390);
        push_marker(OP_CFG_WRITE, RESET_WEEKEND_MASK);
        add_random_beats(390);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || s_axis_tvalid || date_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> files.f
hdl/gcdu_pkg.sv
hdl/gcdu_step.sv
hdl/gcdu_info.sv
hdl/gregorian_calendar_date_unit.sv
bench/gregorian_calendar_date_unit_tb.sv
